// ===== rtl/core/tcce_pkg.sv =====
// Shared types and code constants for the text console character engine.
package tcce_pkg;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [12:0] cell_addr;
  } tcce_in_t;

  typedef struct packed {
    logic [5:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [12:0] cursor_pos;
    logic [31:0] cell_data;
    logic        did_scroll;
  } tcce_out_t;

  localparam logic REQ_DISPLAY = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP    = 8'h90;
  localparam logic [7:0] CH_RIGHT = 8'h91;
  localparam logic [7:0] CH_DOWN  = 8'h92;
  localparam logic [7:0] CH_LEFT  = 8'h93;
  localparam logic [7:0] CH_HOME  = 8'h94;
  localparam logic [7:0] CH_DEL   = 8'h99;

  localparam logic [1:0] REG_NUM_COLS  = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS  = 2'd1;
  localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

endpackage

// ===== rtl/core/tcce_mem.sv =====
// Screen cell store: one write port and one registered read port.
module tcce_mem #(
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tcce_seq.sv =====
// Sequencer: cursor state, request decode and the copy and fill passes over the store.
module tcce_seq #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW    = $clog2(DEPTH),
  localparam int LW    = AW + 1,
  localparam int CLW   = $clog2(MAX_COLS + 1),
  localparam int RLW   = $clog2(MAX_ROWS + 1),
  localparam int COLW  = $clog2(MAX_COLS),
  localparam int ROWW  = $clog2(MAX_ROWS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::tcce_in_t  in_data,
  output logic                out_strobe,
  output tcce_pkg::tcce_out_t out_data,
  input  logic [CLW-1:0]      cols,
  input  logic [RLW-1:0]      rows,
  input  logic [15:0]         attr,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [31:0]         mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [31:0]         mem_rdata
);
  import tcce_pkg::*;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_DELSET = 4'd3;
  localparam logic [3:0] ST_PUT    = 4'd4;
  localparam logic [3:0] ST_COPY   = 4'd5;
  localparam logic [3:0] ST_FILL   = 4'd6;
  localparam logic [3:0] ST_RDWAIT = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]      state_r, state_nxt;
  logic [ROWW-1:0] row_r, row_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   fill_addr_r, fill_addr_nxt;

  tcce_in_t        req_r, req_nxt;
  tcce_out_t       out_r, out_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [2:0]      put_rem_r, put_rem_nxt;
  logic            scroll_r, scroll_nxt;
  logic [31:0]     data_r, data_nxt;
  logic [AW-1:0]   dst_r, dst_nxt;
  logic [CLW-1:0]  off_r, off_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [AW-1:0]   n_r, n_nxt;
  logic [LW-1:0]   fill_left_r, fill_left_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;

  logic [31:0]     base32;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   scroll_len;
  logic [LW-1:0]   total;
  logic [COLW-1:0] cols_m1;
  logic [ROWW-1:0] rows_m1;
  logic            col_last;
  logic            row_last;
  logic            addr_ok;
  logic [31:0]     blank;

  assign base32     = 32'(row_r) * 32'(cols);
  assign pos        = AW'(base32 + 32'(col_r));
  assign scroll_len = AW'(32'(cols) * (32'(rows) - 32'd1));
  assign total      = LW'(32'(cols) * 32'(rows));
  assign cols_m1    = COLW'(32'(cols) - 32'd1);
  assign rows_m1    = ROWW'(32'(rows) - 32'd1);
  assign col_last   = (32'(col_r) + 32'd1) >= 32'(cols);
  assign row_last   = (32'(row_r) + 32'd1) >= 32'(rows);
  assign addr_ok    = 32'(req_r.cell_addr) < 32'(DEPTH);
  assign blank      = {attr, 8'h00, CH_SPACE};

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    out_strobe_nxt = 1'b0;
    pend_nxt       = 1'b0;
    fill_addr_nxt  = fill_addr_r;
    req_nxt        = req_r;
    out_nxt        = out_r;
    code_nxt       = code_r;
    put_rem_nxt    = put_rem_r;
    scroll_nxt     = scroll_r;
    data_nxt       = data_r;
    dst_nxt        = dst_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    n_nxt          = n_r;
    fill_left_nxt  = fill_left_r;
    pend_addr_nxt  = pend_addr_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_addr_r;
    mem_wdata      = 32'd0;
    mem_raddr      = '0;

    case (state_r)
      ST_CLR: begin
        mem_we        = 1'b1;
        fill_addr_nxt = AW'(32'(fill_addr_r) + 32'd1);
        if (32'(fill_addr_r) == 32'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt     = in_data;
          scroll_nxt  = 1'b0;
          data_nxt    = 32'd0;
          put_rem_nxt = 3'd0;
          if (32'(col_r) >= 32'(cols)) begin
            col_nxt = cols_m1;
          end
          if (32'(row_r) >= 32'(rows)) begin
            row_nxt = rows_m1;
          end
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        if (req_r.req_type == REQ_READ) begin
          if (addr_ok) begin
            mem_raddr = AW'(32'(req_r.cell_addr));
          end
          state_nxt = ST_RDWAIT;
        end else begin
          case (req_r.char_code)
            CH_CR: begin
              col_nxt = '0;
            end
            CH_LF: begin
              if (!row_last) begin
                row_nxt = ROWW'(32'(row_r) + 32'd1);
              end else begin
                dst_nxt       = '0;
                off_nxt       = cols;
                len_nxt       = scroll_len;
                n_nxt         = '0;
                fill_addr_nxt = scroll_len;
                fill_left_nxt = LW'(cols);
                scroll_nxt    = 1'b1;
                state_nxt     = ST_COPY;
              end
            end
            CH_RIGHT: begin
              if (!col_last) begin
                col_nxt = COLW'(32'(col_r) + 32'd1);
              end
            end
            CH_UP: begin
              if (row_r != '0) begin
                row_nxt = ROWW'(32'(row_r) - 32'd1);
              end
            end
            CH_LEFT: begin
              if (col_r != '0) begin
                col_nxt = COLW'(32'(col_r) - 32'd1);
              end
            end
            CH_DOWN: begin
              if (!row_last) begin
                row_nxt = ROWW'(32'(row_r) + 32'd1);
              end
            end
            CH_HOME: begin
              if (col_r == '0) begin
                row_nxt = '0;
              end
              col_nxt = '0;
            end
            CH_DEL: begin
              state_nxt = ST_DELSET;
            end
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt   = COLW'(32'(col_r) - 32'd1);
                state_nxt = ST_DELSET;
              end
            end
            CH_FF: begin
              row_nxt       = '0;
              col_nxt       = '0;
              len_nxt       = '0;
              n_nxt         = '0;
              fill_addr_nxt = '0;
              fill_left_nxt = total;
              state_nxt     = ST_FILL;
            end
            CH_TAB: begin
              code_nxt    = CH_SPACE;
              put_rem_nxt = 3'd4;
              state_nxt   = ST_PUT;
            end
            default: begin
              code_nxt    = req_r.char_code;
              put_rem_nxt = 3'd1;
              state_nxt   = ST_PUT;
            end
          endcase
        end
      end
      ST_DELSET: begin
        dst_nxt       = pos;
        off_nxt       = CLW'(1);
        len_nxt       = AW'(32'(cols) - 32'd1 - 32'(col_r));
        n_nxt         = '0;
        fill_addr_nxt = AW'(base32 + 32'(cols) - 32'd1);
        fill_left_nxt = LW'(1);
        state_nxt     = ST_COPY;
      end
      ST_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = pos;
        mem_wdata   = {attr, 8'h00, code_r};
        put_rem_nxt = put_rem_r - 3'd1;
        state_nxt   = (put_rem_r == 3'd1) ? ST_DONE : ST_PUT;
        if (!col_last) begin
          col_nxt = COLW'(32'(col_r) + 32'd1);
        end else begin
          col_nxt = '0;
          if (!row_last) begin
            row_nxt = ROWW'(32'(row_r) + 32'd1);
          end else begin
            dst_nxt       = '0;
            off_nxt       = cols;
            len_nxt       = scroll_len;
            n_nxt         = '0;
            fill_addr_nxt = scroll_len;
            fill_left_nxt = LW'(cols);
            scroll_nxt    = 1'b1;
            state_nxt     = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        mem_raddr = AW'(32'(dst_r) + 32'(n_r) + 32'(off_r));
        if (n_r < len_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(32'(dst_r) + 32'(n_r));
          n_nxt         = AW'(32'(n_r) + 32'd1);
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we        = 1'b1;
        mem_waddr     = fill_addr_r;
        mem_wdata     = blank;
        fill_addr_nxt = AW'(32'(fill_addr_r) + 32'd1);
        fill_left_nxt = LW'(32'(fill_left_r) - 32'd1);
        if (32'(fill_left_r) == 32'd1) begin
          state_nxt = (put_rem_r != 3'd0) ? ST_PUT : ST_DONE;
        end
      end
      ST_RDWAIT: begin
        data_nxt  = addr_ok ? mem_rdata : 32'd0;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_nxt.cursor_row = 6'(row_r);
        out_nxt.cursor_col = 7'(col_r);
        out_nxt.cursor_pos = 13'(pos);
        out_nxt.cell_data  = data_r;
        out_nxt.did_scroll = scroll_r;
        out_strobe_nxt     = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      row_r        <= '0;
      col_r        <= '0;
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
      fill_addr_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      out_strobe_r <= out_strobe_nxt;
      pend_r       <= pend_nxt;
      fill_addr_r  <= fill_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    out_r       <= out_nxt;
    code_r      <= code_nxt;
    put_rem_r   <= put_rem_nxt;
    scroll_r    <= scroll_nxt;
    data_r      <= data_nxt;
    dst_r       <= dst_nxt;
    off_r       <= off_nxt;
    len_r       <= len_nxt;
    n_r         <= n_nxt;
    fill_left_r <= fill_left_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ===== rtl/core/text_console_char_engine.sv =====
// Top level of the text console character engine: register port, sequencer and cell store.
//
//   Channel  Ports                                        Beat taken when
//   in       start, busy, in_data                         start high and busy low
//   out      out_strobe, out_data                         out_strobe high (one cycle)
//   cfg      psel, penable, pwrite, paddr, pwdata, prdata  psel, penable, pwrite high
//
// After reset the store is cleared to zero one cell a cycle, all MAX_COLS*MAX_ROWS cells
// (8192 at the defaults), with busy high. A cursor beat passes through the decode and
// done states before its out_strobe; a read adds the read wait state, a printed character
// the put state. A scroll copies and blanks cells one a cycle through the store's single
// write port; a delete copies the rest of the row and a form feed blanks all cols*rows cells.
// A tab can scroll up to four times. The receiver cannot stall, so out_strobe is never held.
module text_console_char_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::tcce_in_t  in_data,
  output logic                out_strobe,
  output tcce_pkg::tcce_out_t out_data
);
  import tcce_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int RLW   = $clog2(MAX_ROWS + 1);

  logic [7:0]     num_cols_r;
  logic [6:0]     num_rows_r;
  logic [15:0]    attr_r;
  logic           cfg_wr;
  logic [CLW-1:0] cols_eff;
  logic [RLW-1:0] rows_eff;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    mem_rdata;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= 8'd80;
      num_rows_r <= 7'd32;
      attr_r     <= 16'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NUM_COLS:  num_cols_r <= pwdata[7:0];
        REG_NUM_ROWS:  num_rows_r <= pwdata[6:0];
        REG_ATTRIBUTE: attr_r     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_COLS:  prdata = {24'd0, num_cols_r};
      REG_NUM_ROWS:  prdata = {25'd0, num_rows_r};
      REG_ATTRIBUTE: prdata = {16'd0, attr_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (num_cols_r == 8'd0) begin
      cols_eff = CLW'(1);
    end else if (32'(num_cols_r) > 32'(MAX_COLS)) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = CLW'(num_cols_r);
    end
    if (num_rows_r == 7'd0) begin
      rows_eff = RLW'(1);
    end else if (32'(num_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RLW'(MAX_ROWS);
    end else begin
      rows_eff = RLW'(num_rows_r);
    end
  end

  tcce_seq #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cols       (cols_eff),
    .rows       (rows_eff),
    .attr       (attr_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcce_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/text_console_char_engine_test.sv =====
// Self-checking testbench for the text console character engine with a cursor and cell predictor.
module text_console_char_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int unsigned COLS_MAX    = 128;
  localparam int unsigned ROWS_MAX    = 64;
  localparam int unsigned CELL_DEPTH  = COLS_MAX * ROWS_MAX;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 50;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  tcce_in_t    in_data;
  logic        out_strobe;
  tcce_out_t   out_data;

  tcce_in_t    char_stream[$];
  tcce_out_t   awaited_reports[$];
  logic        beat_taken;
  int unsigned gap_pct;
  int unsigned fault_count;
  int unsigned cycle_count;

  logic [31:0] shadow_cells [0:CELL_DEPTH-1];
  int unsigned cur_r;
  int unsigned cur_c;
  logic [7:0]  reg_cols;
  logic [6:0]  reg_rows;
  logic [15:0] reg_attr;

  text_console_char_engine #(
    .MAX_COLS(COLS_MAX),
    .MAX_ROWS(ROWS_MAX)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_cols();
    if (reg_cols == 0) return 1;
    return (32'(reg_cols) > COLS_MAX) ? COLS_MAX : 32'(reg_cols);
  endfunction

  function automatic int unsigned eff_rows();
    if (reg_rows == 0) return 1;
    return (32'(reg_rows) > ROWS_MAX) ? ROWS_MAX : 32'(reg_rows);
  endfunction

  function automatic logic [31:0] blank_word();
    return {reg_attr, 8'h00, CH_SPACE};
  endfunction

  task automatic next_line(input int unsigned cols, input int unsigned rows,
                           output bit scrolled);
    int unsigned n;
    scrolled = 1'b0;
    if (cur_r + 1 < rows) begin
      cur_r++;
    end else begin
      for (n = 0; n < cols * (rows - 1); n++) shadow_cells[n] = shadow_cells[n + cols];
      for (n = 0; n < cols; n++) shadow_cells[cols * (rows - 1) + n] = blank_word();
      scrolled = 1'b1;
    end
  endtask

  task automatic put_glyph(input logic [7:0] code, input int unsigned cols,
                           input int unsigned rows, output bit scrolled);
    shadow_cells[cur_r * cols + cur_c] = {reg_attr, 8'h00, code};
    cur_c++;
    scrolled = 1'b0;
    if (cur_c >= cols) begin
      cur_c = 0;
      next_line(cols, rows, scrolled);
    end
  endtask

  task automatic erase_at_cursor(input int unsigned cols);
    int unsigned base;
    int unsigned n;
    base = cur_r * cols;
    for (n = cur_c; n + 1 < cols; n++) shadow_cells[base + n] = shadow_cells[base + n + 1];
    shadow_cells[base + cols - 1] = blank_word();
  endtask

  task automatic console_update(input tcce_in_t beat, output tcce_out_t rep);
    int unsigned cols;
    int unsigned rows;
    int unsigned n;
    logic [31:0] data;
    bit          sc;
    bit          any;
    cols = eff_cols();
    rows = eff_rows();
    data = '0;
    any  = 1'b0;
    if (cur_c >= cols) cur_c = cols - 1;
    if (cur_r >= rows) cur_r = rows - 1;
    if (beat.req_type == REQ_READ) begin
      if (beat.cell_addr < CELL_DEPTH) data = shadow_cells[beat.cell_addr];
    end else begin
      case (beat.char_code)
        CH_CR:    cur_c = 0;
        CH_LF:    next_line(cols, rows, any);
        CH_RIGHT: if (cur_c + 1 < cols) cur_c++;
        CH_UP:    if (cur_r > 0) cur_r--;
        CH_LEFT:  if (cur_c > 0) cur_c--;
        CH_DOWN:  if (cur_r + 1 < rows) cur_r++;
        CH_HOME: begin
          if (cur_c == 0) cur_r = 0;
          cur_c = 0;
        end
        CH_DEL:   erase_at_cursor(cols);
        CH_BS: begin
          if (cur_c > 0) begin
            cur_c--;
            erase_at_cursor(cols);
          end
        end
        CH_FF: begin
          for (n = 0; n < cols * rows; n++) shadow_cells[n] = blank_word();
          cur_r = 0;
          cur_c = 0;
        end
        CH_TAB: begin
          for (n = 0; n < 4; n++) begin
            put_glyph(CH_SPACE, cols, rows, sc);
            any |= sc;
          end
        end
        default:  put_glyph(beat.char_code, cols, rows, any);
      endcase
    end
    rep.cursor_row = 6'(cur_r);
    rep.cursor_col = 7'(cur_c);
    rep.cursor_pos = 13'(cur_r * cols + cur_c);
    rep.cell_data  = data;
    rep.did_scroll = any;
  endtask

  function automatic tcce_in_t display_beat(input logic [7:0] code);
    tcce_in_t b;
    b.req_type  = REQ_DISPLAY;
    b.char_code = code;
    b.cell_addr = 13'($urandom);
    return b;
  endfunction

  function automatic tcce_in_t read_beat(input logic [12:0] addr);
    tcce_in_t b;
    b.req_type  = REQ_READ;
    b.char_code = 8'($urandom);
    b.cell_addr = addr;
    return b;
  endfunction

  function automatic tcce_in_t random_beat(input int unsigned cells);
    tcce_in_t    b;
    int unsigned pick;
    b = display_beat(8'($urandom));
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      b = read_beat(13'($urandom));
      if (pick < 11) b.cell_addr = 13'($urandom_range(cells - 1, 0));
    end else if (pick < 50) begin
      case ($urandom_range(11, 0))
        0:       b.char_code = CH_BS;
        1:       b.char_code = CH_TAB;
        2:       b.char_code = CH_LF;
        3:       b.char_code = CH_FF;
        4:       b.char_code = CH_CR;
        5:       b.char_code = CH_UP;
        6:       b.char_code = CH_RIGHT;
        7:       b.char_code = CH_DOWN;
        8:       b.char_code = CH_LEFT;
        9:       b.char_code = CH_HOME;
        10:      b.char_code = CH_DEL;
        default: b.char_code = CH_SPACE;
      endcase
    end else if (pick < 90) begin
      b.char_code = 8'($urandom_range(8'h7e, 8'h21));
    end
    return b;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_NUM_COLS:  reg_cols = value[7:0];
      REG_NUM_ROWS:  reg_rows = value[6:0];
      REG_ATTRIBUTE: reg_attr = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [6:0] rows,
                              input logic [15:0] attr);
    write_reg(REG_NUM_COLS, {24'h0, cols});
    write_reg(REG_NUM_ROWS, {25'h0, rows});
    write_reg(REG_ATTRIBUTE, {16'h0, attr});
  endtask

  // Waits until every queued beat has been taken and answered and the block is idle.
  task automatic settle();
    do @(posedge clk);
    while (char_stream.size() != 0 || start !== 1'b0 || awaited_reports.size() != 0 ||
           busy !== 1'b0);
  endtask

  always @(posedge clk) begin : take_beat
    tcce_out_t rep;
    beat_taken <= rst_n && start && (busy === 1'b0);
    if (rst_n && start && (busy === 1'b0)) begin
      console_update(in_data, rep);
      awaited_reports.push_back(rep);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!start || beat_taken)) begin
      if (char_stream.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
        in_data <= char_stream.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : report_check
    tcce_out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        $error("out_strobe with no report awaited");
        fault_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("cursor_row", 32'(want.cursor_row), 32'(out_data.cursor_row));
        check_field("cursor_col", 32'(want.cursor_col), 32'(out_data.cursor_col));
        check_field("cursor_pos", 32'(want.cursor_pos), 32'(out_data.cursor_pos));
        check_field("cell_data", want.cell_data, out_data.cell_data);
        check_field("did_scroll", 32'(want.did_scroll), 32'(out_data.did_scroll));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned batch;
    clk         = 1'b0;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    start       = 1'b0;
    in_data     = '0;
    beat_taken  = 1'b0;
    gap_pct     = 36;
    fault_count = 0;
    cycle_count = 0;
    batch       = 0;
    cur_r       = 0;
    cur_c       = 0;
    reg_cols    = 8'd80;
    reg_rows    = 7'd32;
    reg_attr    = 16'h0000;
    for (k = 0; k < CELL_DEPTH; k++) shadow_cells[k] = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    settle();

    set_geometry(8'd5, 7'd3, 16'hA5C3);
    char_stream.push_back(display_beat(CH_UP));
    char_stream.push_back(display_beat(CH_LEFT));
    char_stream.push_back(display_beat(CH_BS));
    char_stream.push_back(display_beat(8'h00));
    char_stream.push_back(display_beat(8'hFF));
    char_stream.push_back(display_beat(8'h61));
    char_stream.push_back(display_beat(CH_RIGHT));
    char_stream.push_back(display_beat(CH_RIGHT));
    char_stream.push_back(display_beat(CH_RIGHT));
    char_stream.push_back(display_beat(CH_DEL));
    char_stream.push_back(display_beat(CH_LEFT));
    char_stream.push_back(display_beat(CH_BS));
    char_stream.push_back(display_beat(CH_DOWN));
    char_stream.push_back(display_beat(CH_DOWN));
    char_stream.push_back(display_beat(CH_DOWN));
    char_stream.push_back(display_beat(CH_LF));
    char_stream.push_back(display_beat(CH_TAB));
    char_stream.push_back(display_beat(CH_TAB));
    char_stream.push_back(display_beat(CH_HOME));
    char_stream.push_back(display_beat(CH_HOME));
    char_stream.push_back(display_beat(8'h7A));
    char_stream.push_back(display_beat(CH_CR));
    char_stream.push_back(read_beat(13'd0));
    char_stream.push_back(read_beat(13'h1FFF));
    char_stream.push_back(read_beat(13'd7));
    char_stream.push_back(display_beat(CH_FF));
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_geometry(8'd7, 7'd4, 16'($urandom));
          gap_pct = 36;
          batch   = 16;
        end
        1: begin
          set_geometry(8'd0, 7'd0, 16'h0000);
          gap_pct = 36;
          batch   = 6;
        end
        2: begin
          set_geometry(8'd16, 7'd1, 16'hFFFF);
          gap_pct = 50;
          batch   = 16;
        end
        3: begin
          set_geometry(8'd255, 7'd127, 16'($urandom));
          gap_pct = 50;
          batch   = 6;
        end
        4: begin
          set_geometry(8'd3, 7'd64, 16'hFFFF);
          gap_pct = 0;
          batch   = 15;
        end
        default: begin
          set_geometry(8'd10, 7'd2, 16'($urandom));
          gap_pct = 0;
          batch   = 15;
        end
      endcase
      for (k = 0; k < batch; k++) char_stream.push_back(random_beat(eff_cols() * eff_rows()));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
